@@ src/sync_length_xor_frame_receiver_defines.svh @@
// Assertion macros for the sync/length/XOR frame receiver.
// Simulation builds check; synthesis builds see empty bodies.
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
`define SLXFR_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("slxfr: same-cycle check failed");
`define SLXFR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("slxfr: next-cycle check failed");
`else
`define SLXFR_ASSERT_NOW(lbl, pre, post)
`define SLXFR_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ src/slxfr_pkg.sv @@
// Shared widths, sync codes and the frame descriptor type for the
// sync/length/XOR frame receiver. No dependencies.
package slxfr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h06;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h85;

    typedef struct packed {
        logic [LEN_W-1:0] len;
    } t_frame_desc;

endpackage

@@ src/sync_length_xor_frame_receiver.sv @@
// Sync/length framed byte receiver with XOR checksum, top level.
// Instantiates slxfr_front, slxfr_queue and slxfr_back; uses slxfr_pkg.
//
// Input channel: i_valid / o_stall carry one received byte (i_rx_byte).
// The front end hunts for 0x06, 0x85 and a length byte equal to the
// configured length, stores that many payload bytes and folds an XOR
// checksum seeded with the length. A matching checksum byte queues the
// frame; a mismatch drops it without output.
// Output channel: o_valid / i_stall carry one payload byte per item with
// its index and a last marker. Readout starts after the checksum byte is
// taken and its descriptor is popped by the idle back end, and then gives
// one byte per cycle while i_stall is low. Input bytes are taken one per
// cycle unless o_stall is high; a payload byte waits while an earlier frame
// is queued or still being read out of the payload store (one read port).
// A stalled output keeps its byte while the input side keeps parsing.
// Configuration: i_cfg_valid / o_cfg_ready write the expected length; any
// write aborts a frame in progress. Reset returns to the hunt with the
// length set to 1 and nothing pending.
module sync_length_xor_frame_receiver #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [slxfr_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [slxfr_pkg::BYTE_W-1:0]   o_payload_byte,
    output logic [slxfr_pkg::IDX_W-1:0]    o_byte_index,
    output logic                           o_last_byte,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [slxfr_pkg::LEN_W-1:0]    i_expected_length
);
    import slxfr_pkg::*;

    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W = AW + 1;

    logic              push;
    t_frame_desc       push_desc;
    t_frame_desc       head_desc;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              back_busy;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;

    assign o_cfg_ready = 1'b1;

    slxfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW),
        .CNT_W       (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_len   (i_expected_length),
        .i_q_empty   (q_empty),
        .i_q_full    (q_full),
        .i_back_busy (back_busy),
        .o_push      (push),
        .o_desc      (push_desc),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    slxfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_desc  (head_desc),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    slxfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW),
        .CNT_W       (CNT_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (wr_en),
        .i_wr_addr      (wr_addr),
        .i_wr_data      (wr_data),
        .i_desc         (head_desc),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .o_busy         (back_busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last_byte    (o_last_byte)
    );

endmodule

@@ src/slxfr_front.sv @@
// Front end: sync hunt, length check, payload store writes and XOR checksum.
// Pushes a frame descriptor on a checksum match. Depends on slxfr_pkg.
module slxfr_front #(
    parameter int MAX_PAYLOAD = 64,
    parameter int AW          = 6,
    parameter int CNT_W       = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [slxfr_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                           i_cfg_valid,
    input  logic [slxfr_pkg::LEN_W-1:0]    i_cfg_len,
    input  logic                           i_q_empty,
    input  logic                           i_q_full,
    input  logic                           i_back_busy,
    output logic                           o_push,
    output slxfr_pkg::t_frame_desc         o_desc,
    output logic                           o_wr_en,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [slxfr_pkg::BYTE_W-1:0]   o_wr_data
);
    import slxfr_pkg::*;

    localparam logic [2:0] PH_HUNT0 = 3'd0;
    localparam logic [2:0] PH_HUNT1 = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;

    logic [2:0]        r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_csum, n_csum;
    logic [LEN_W-1:0]  r_exp_len;
    logic              in_acc;
    logic              len_ok;

    assign o_stall = ((r_phase == PH_DATA) && (!i_q_empty || i_back_busy)) ||
                     ((r_phase == PH_CHECK) && i_q_full);
    assign in_acc  = i_valid && !o_stall;
    assign len_ok  = (r_exp_len >= LEN_W'(1)) && (r_exp_len <= LEN_W'(MAX_PAYLOAD)) &&
                     (i_rx_byte == {1'b0, r_exp_len});

    assign o_wr_en   = in_acc && (r_phase == PH_DATA);
    assign o_wr_addr = r_cnt[AW-1:0];
    assign o_wr_data = i_rx_byte;
    assign o_push    = in_acc && (r_phase == PH_CHECK) && (i_rx_byte == r_csum);
    assign o_desc    = '{len: LEN_W'(r_cnt)};

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_csum  = r_csum;
        if (in_acc) begin
            unique case (r_phase)
                PH_HUNT0: begin
                    if (i_rx_byte == SYNC_FIRST) n_phase = PH_HUNT1;
                end
                PH_HUNT1: begin
                    if (i_rx_byte == SYNC_SECOND) n_phase = PH_LEN;
                    else if (i_rx_byte != SYNC_FIRST) n_phase = PH_HUNT0;
                end
                PH_LEN: begin
                    if (len_ok) begin
                        n_phase = PH_DATA;
                        n_csum  = i_rx_byte;
                        n_cnt   = '0;
                    end else begin
                        n_phase = PH_HUNT0;
                        n_csum  = '0;
                        n_cnt   = '0;
                    end
                end
                PH_DATA: begin
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_csum = r_csum ^ i_rx_byte;
                    if ((LEN_W'(r_cnt) + LEN_W'(1)) >= r_exp_len) n_phase = PH_CHECK;
                end
                default: begin
                    n_phase = PH_HUNT0;
                    n_csum  = '0;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT0;
            r_cnt     <= '0;
            r_csum    <= '0;
            r_exp_len <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            r_exp_len <= i_cfg_len;
            r_phase   <= PH_HUNT0;
            r_cnt     <= '0;
            r_csum    <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_csum  <= n_csum;
        end
    end

endmodule

@@ src/slxfr_queue.sv @@
// Two-entry descriptor queue between front and back ends.
// Depends on slxfr_pkg.
module slxfr_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  slxfr_pkg::t_frame_desc i_desc,
    input  logic                   i_pop,
    output slxfr_pkg::t_frame_desc o_desc,
    output logic                   o_empty,
    output logic                   o_full
);
    import slxfr_pkg::*;

    t_frame_desc r_entry [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        do_push;
    logic        do_pop;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_desc  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_entry[r_wr_ptr] <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

@@ src/slxfr_back.sv @@
// Back end: payload store, readout sequencer and output register.
// Depends on slxfr_pkg and the assertion macro header.
`include "sync_length_xor_frame_receiver_defines.svh"
module slxfr_back #(
    parameter int MAX_PAYLOAD = 64,
    parameter int AW          = 6,
    parameter int CNT_W       = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [AW-1:0]                  i_wr_addr,
    input  logic [slxfr_pkg::BYTE_W-1:0]   i_wr_data,
    input  slxfr_pkg::t_frame_desc         i_desc,
    input  logic                           i_q_empty,
    output logic                           o_pop,
    output logic                           o_busy,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [slxfr_pkg::BYTE_W-1:0]   o_payload_byte,
    output logic [slxfr_pkg::IDX_W-1:0]    o_byte_index,
    output logic                           o_last_byte
);
    import slxfr_pkg::*;

    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  r_len;
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_rd_data;
    logic [AW-1:0]     r_s1_idx;
    logic              r_s1_last;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [AW-1:0]     r_out_idx;
    logic              r_out_last;
    logic              out_load;
    logic              s1_move;
    logic              issue;
    logic              issue_last;

    assign out_load   = !r_out_valid || !i_stall;
    assign s1_move    = r_s1_valid && out_load;
    assign issue      = r_busy && (!r_s1_valid || out_load);
    assign issue_last = (LEN_W'(r_cnt) + LEN_W'(1)) == r_len;
    assign o_pop      = !r_busy && !i_q_empty;
    assign o_busy     = r_busy;

    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_byte_index   = IDX_W'(r_out_idx);
    assign o_last_byte    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_cnt[AW-1:0]];
            r_s1_idx  <= r_cnt[AW-1:0];
            r_s1_last <= issue_last;
        end
        if (s1_move) begin
            r_out_byte <= r_rd_data;
            r_out_idx  <= r_s1_idx;
            r_out_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_len       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_len  <= i_desc.len;
            end else if (issue) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (issue_last) r_busy <= 1'b0;
            end
            if (issue) r_s1_valid <= 1'b1;
            else if (s1_move) r_s1_valid <= 1'b0;
            if (s1_move) r_out_valid <= 1'b1;
            else if (out_load) r_out_valid <= 1'b0;
        end
    end

    `SLXFR_ASSERT_NOW(a_no_write_during_readout, i_wr_en, !r_busy)
    `SLXFR_ASSERT_NOW(a_read_in_range, r_busy, LEN_W'(r_cnt) < r_len)
    `SLXFR_ASSERT_NEXT(a_last_ends_readout, issue && issue_last, !r_busy)
    `SLXFR_ASSERT_NEXT(a_stalled_out_holds, r_out_valid && i_stall, r_out_valid)

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sync_length_xor_frame_receiver: random and directed
// received bytes, an in-bench frame tracker predicting delivered payload items.
// Depends on slxfr_pkg and the receiver RTL only.
module testbench;
    import slxfr_pkg::*;

    localparam int MAX_PAYLOAD = 64;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [2:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        WAIT_LEN,
        TAKE_DATA,
        TAKE_CHECK
    } t_rx_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_payload_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [BYTE_W-1:0] i_rx_byte = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [BYTE_W-1:0] o_payload_byte;
    logic [IDX_W-1:0]  o_byte_index;
    logic              o_last_byte;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [LEN_W-1:0]  i_expected_length = 7'd1;

    logic [BYTE_W-1:0] rx_items_q[$];
    t_payload_beat     payload_expect_q[$];

    t_rx_phase         trk_phase = HUNT_SYNC1;
    logic [LEN_W-1:0]  trk_len = 7'd1;
    logic [6:0]        trk_count = '0;
    logic [BYTE_W-1:0] trk_csum = '0;
    logic [BYTE_W-1:0] trk_store[MAX_PAYLOAD];

    int idle_mode = 0;
    int n_pushed = 0;
    int n_taken = 0;
    int n_frames = 0;
    int n_beats = 0;
    int n_settings = 0;
    int err_cnt = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    t_payload_beat got_beat;
    t_payload_beat want_beat;

    int cfg_len[7] = '{1, 64, 6, 0, 2, 9, 127};
    int cfg_budget[7] = '{30, 100, 40, 15, 30, 35, 15};

    sync_length_xor_frame_receiver #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_last_byte      (o_last_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_expected_length(i_expected_length)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit coin(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void frame_clear();
        trk_phase = HUNT_SYNC1;
        trk_count = '0;
        trk_csum = '0;
    endfunction

    function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
        t_payload_beat beat;
        case (trk_phase)
            HUNT_SYNC1: begin
                if (b == SYNC_FIRST) trk_phase = HUNT_SYNC2;
            end
            HUNT_SYNC2: begin
                if (b == SYNC_SECOND) trk_phase = WAIT_LEN;
                else if (b != SYNC_FIRST) trk_phase = HUNT_SYNC1;
            end
            WAIT_LEN: begin
                if (trk_len >= 1 && trk_len <= MAX_PAYLOAD && b == {1'b0, trk_len}) begin
                    trk_csum = b;
                    trk_count = '0;
                    trk_phase = TAKE_DATA;
                end else begin
                    frame_clear();
                end
            end
            TAKE_DATA: begin
                if (trk_count < MAX_PAYLOAD) begin
                    trk_store[trk_count[IDX_W-1:0]] = b;
                    trk_count = trk_count + 1'b1;
                end
                trk_csum = trk_csum ^ b;
                if (trk_count >= trk_len || trk_count >= MAX_PAYLOAD) trk_phase = TAKE_CHECK;
            end
            TAKE_CHECK: begin
                if (b == trk_csum) begin
                    for (int k = 0; k < trk_count; k++) begin
                        beat.data = trk_store[k[IDX_W-1:0]];
                        beat.idx = k[IDX_W-1:0];
                        beat.last = (k + 1 == trk_count);
                        payload_expect_q.insert(payload_expect_q.size(), beat);
                    end
                    n_frames++;
                end
                frame_clear();
            end
            default: frame_clear();
        endcase
    endfunction

    // Driver: take the accepted item into the tracker, hold a stalled item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                track_rx_byte(i_rx_byte);
                n_taken++;
            end
            if (i_valid && o_stall) begin
                i_valid <= 1'b1;
            end else if (rx_items_q.size() != 0 &&
                         !coin(idle_mode == 0 ? 37 : (idle_mode == 1 ? 56 : 0))) begin
                i_valid <= 1'b1;
                i_rx_byte <= rx_items_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= (hold_left != 0) ||
                       coin(idle_mode == 0 ? 56 : (idle_mode == 1 ? 37 : 0));
        end
    end

    // Monitor: compare each delivered item with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_beat = '{o_payload_byte, o_byte_index, o_last_byte};
            if (payload_expect_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected item: data=%h idx=%0d last=%b",
                             got_beat.data, got_beat.idx, got_beat.last);
            end else begin
                want_beat = payload_expect_q.pop_front();
                n_beats++;
                if (got_beat != want_beat) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"mismatch: expected data=%h idx=%0d last=%b, ",
                                  "got data=%h idx=%0d last=%b"},
                                 want_beat.data, want_beat.idx, want_beat.last,
                                 got_beat.data, got_beat.idx, got_beat.last);
                end
            end
        end
    end

    function automatic void put_rx(input logic [BYTE_W-1:0] b);
        rx_items_q.insert(rx_items_q.size(), b);
        n_pushed++;
    endfunction

    task automatic write_length(input logic [LEN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_expected_length <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        trk_len = v;
        frame_clear();
        n_settings++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (n_taken != n_pushed || payload_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic gen_traffic(input int len, input int budget);
        int start;
        int pick;
        int nbytes;
        logic [BYTE_W-1:0] announce;
        logic [BYTE_W-1:0] csum;
        logic [BYTE_W-1:0] b;
        start = n_pushed;
        while (n_pushed - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                repeat ($urandom_range(0, 2)) put_rx(BYTE_W'($urandom_range(0, 255)));
                if (len >= 1 && len <= MAX_PAYLOAD) begin
                    announce = BYTE_W'(len);
                    nbytes = len;
                end else begin
                    announce = coin(50) ? BYTE_W'(len)
                                        : BYTE_W'($urandom_range(1, MAX_PAYLOAD));
                    nbytes = $urandom_range(1, 8);
                end
                put_rx(SYNC_FIRST);
                put_rx(SYNC_SECOND);
                put_rx(announce);
                csum = announce;
                repeat (nbytes) begin
                    b = BYTE_W'($urandom_range(0, 255));
                    csum = csum ^ b;
                    put_rx(b);
                end
                if ($urandom_range(0, 4) == 0) csum = csum ^ (8'h01 << $urandom_range(0, 7));
                put_rx(csum);
            end else if (pick < 85) begin
                put_rx(SYNC_FIRST);
                put_rx(SYNC_SECOND);
                put_rx(len[7:0] ^ (8'h01 << $urandom_range(0, 7)));
                repeat ($urandom_range(1, 3)) put_rx(BYTE_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4))
                    put_rx(coin(25) ? SYNC_FIRST : BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_length(7'd3);
        put_rx(8'h06); put_rx(8'h85); put_rx(8'h03);
        put_rx(8'h00); put_rx(8'hFF); put_rx(8'h80); put_rx(8'h7C);
        put_rx(8'h06); put_rx(8'h06); put_rx(8'h85); put_rx(8'h03);
        put_rx(8'hAA); put_rx(8'h55); put_rx(8'h01); put_rx(8'hFD);
        put_rx(8'h06); put_rx(8'h85); put_rx(8'h03);
        put_rx(8'h11); put_rx(8'h22); put_rx(8'h33); put_rx(8'h00);
        put_rx(8'h06); put_rx(8'h85); put_rx(8'h83);
        // leave a frame open so the next length write aborts it
        put_rx(8'h06); put_rx(8'h85); put_rx(8'h03); put_rx(8'hAA);
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            idle_mode = (p < 2) ? 0 : ((p < 5) ? 1 : 2);
            write_length(LEN_W'(cfg_len[p]));
            gen_traffic(cfg_len[p], cfg_budget[p]);
            if (cfg_len[p] == MAX_PAYLOAD && hold_req == 0) hold_req++;
            wait_drained();
        end

        if (payload_expect_q.size() != 0) begin
            err_cnt++;
            $display("%0d expected items never delivered", payload_expect_q.size());
        end
        $display("sent %0d received bytes under %0d length settings",
                 n_taken, n_settings);
        $display("delivered %0d frames, %0d payload items checked, %0d errors",
                 n_frames, n_beats, err_cnt);
        if (err_cnt == 0) begin
            $display("sync_length_xor_frame_receiver test passed");
        end else begin
            $display("sync_length_xor_frame_receiver test failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout waiting for the receiver to drain");
        $display("sync_length_xor_frame_receiver test failed");
        $finish;
    end

endmodule
